FILE: rtl/rtc_pkg.sv
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants for the calendar clock
// Command codes, field widths, the clock state record and the month length.
// ----------------------------------------------------------------------------
package rtc_pkg;

  // command codes carried in tuser
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_SET_TIME  = 3'd1;
  localparam logic [2:0] CMD_SET_DATE  = 3'd2;
  localparam logic [2:0] CMD_SET_ALARM = 3'd3;
  localparam logic [2:0] CMD_ACK       = 3'd4;

  localparam int CMD_W       = 3;
  localparam int YEAR_W      = 6;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 40;

  localparam int YEAR_MAX_DEF = 50;
  localparam int YEAR_RST     = 16;

  localparam logic [5:0] SEC_LAST   = 6'd59;
  localparam logic [5:0] MIN_LAST   = 6'd59;
  localparam logic [4:0] HOUR_LAST  = 5'd23;
  localparam logic [3:0] MONTH_LAST = 4'd12;
  localparam logic [2:0] WDAY_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [4:0] day_in;
    logic [3:0] month_in;
    logic [5:0] year_in;
    logic [2:0] weekday_in;
    logic       alarm_enable_in;
  } item_t;

  // everything but the year, whose width follows the year limit
  typedef struct packed {
    logic       half_phase;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [4:0] day_of_month;
    logic [3:0] month_now;
    logic [2:0] weekday_now;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       armed;
    logic       ringing;
  } clock_state_t;

  localparam clock_state_t CLOCK_RST = '{
    half_phase:   1'b0,
    seconds:      6'd0,
    minutes:      6'd0,
    hours:        5'd0,
    day_of_month: 5'd1,
    month_now:    4'd1,
    weekday_now:  3'd1,
    alarm_hour:   5'd0,
    alarm_minute: 6'd0,
    armed:        1'b1,
    ringing:      1'b0
  };

  // days in a month; codes outside 1..12 count as 31
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/rtc_step.sv
// ----------------------------------------------------------------------------
// rtc_step: next clock state for one command
// Tick carry chain, set time/date/alarm with saturation, alarm acknowledge
// and the alarm compare, all in one combinational pass.
// ----------------------------------------------------------------------------
module rtc_step #(
  parameter int YEAR_MAX = rtc_pkg::YEAR_MAX_DEF,
  parameter int YW       = 6
) (
  input  rtc_pkg::clock_state_t cur,
  input  logic [YW-1:0]         cur_year,
  input  rtc_pkg::item_t        item,
  output rtc_pkg::clock_state_t nxt,
  output logic [YW-1:0]         nxt_year
);
  import rtc_pkg::*;

  localparam int YXW = (YW > YEAR_W) ? YW : YEAR_W;

  logic            sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap, year_wrap;
  logic [4:0]      cur_len, set_len;
  logic [3:0]      set_month;
  logic [YXW-1:0]  year_in_x;
  logic [YW-1:0]   set_year;
  clock_state_t    upd;
  logic [YW-1:0]   upd_year;

  assign cur_len    = month_len(cur.month_now, cur_year[1:0] == 2'b00);
  assign sec_wrap   = cur.seconds >= SEC_LAST;
  assign min_wrap   = cur.minutes >= MIN_LAST;
  assign hour_wrap  = cur.hours >= HOUR_LAST;
  assign day_wrap   = cur.day_of_month >= cur_len;
  assign month_wrap = cur.month_now >= MONTH_LAST;
  assign year_wrap  = cur_year >= YW'(YEAR_MAX);

  // date inputs clamped into range
  assign set_month = (item.month_in == 4'd0) ? 4'd1 :
                     (item.month_in > MONTH_LAST) ? MONTH_LAST : item.month_in;
  assign year_in_x = YXW'(item.year_in);
  assign set_year  = (year_in_x > YXW'(YEAR_MAX)) ? YW'(YEAR_MAX) : YW'(year_in_x);
  assign set_len   = month_len(set_month, set_year[1:0] == 2'b00);

  always_comb begin
    upd      = cur;
    upd_year = cur_year;
    unique case (item.command)
      CMD_TICK: begin
        upd.half_phase = ~cur.half_phase;
        if (cur.half_phase) begin
          if (!sec_wrap) begin
            upd.seconds = cur.seconds + 6'd1;
          end else begin
            upd.seconds = 6'd0;
            if (!min_wrap) begin
              upd.minutes = cur.minutes + 6'd1;
            end else begin
              upd.minutes = 6'd0;
              if (!hour_wrap) begin
                upd.hours = cur.hours + 5'd1;
              end else begin
                upd.hours = 5'd0;
                upd.weekday_now = (cur.weekday_now >= WDAY_LAST) ? 3'd1
                                                                 : cur.weekday_now + 3'd1;
                if (!day_wrap) begin
                  upd.day_of_month = cur.day_of_month + 5'd1;
                end else begin
                  upd.day_of_month = 5'd1;
                  if (!month_wrap) begin
                    upd.month_now = cur.month_now + 4'd1;
                  end else begin
                    upd.month_now = 4'd1;
                    upd_year = year_wrap ? '0 : cur_year + YW'(1);
                  end
                end
              end
            end
          end
        end
      end
      CMD_SET_TIME: begin
        upd.hours   = (item.hour_in > HOUR_LAST) ? HOUR_LAST : item.hour_in;
        upd.minutes = (item.minute_in > MIN_LAST) ? MIN_LAST : item.minute_in;
        upd.seconds = 6'd0;
      end
      CMD_SET_DATE: begin
        upd.month_now    = set_month;
        upd_year         = set_year;
        upd.day_of_month = (item.day_in == 5'd0) ? 5'd1 :
                           (item.day_in > set_len) ? set_len : item.day_in;
        upd.weekday_now  = (item.weekday_in == 3'd0) ? 3'd1 : item.weekday_in;
      end
      CMD_SET_ALARM: begin
        upd.alarm_hour   = (item.hour_in > HOUR_LAST) ? HOUR_LAST : item.hour_in;
        upd.alarm_minute = (item.minute_in > MIN_LAST) ? MIN_LAST : item.minute_in;
        upd.armed        = item.alarm_enable_in;
      end
      CMD_ACK: begin
        if (cur.ringing) begin
          upd.ringing = 1'b0;
          upd.armed   = 1'b0;
        end
      end
      default: begin
      end
    endcase
    // alarm compare runs after every command
    if (upd.armed && upd.hours == upd.alarm_hour && upd.minutes == upd.alarm_minute) begin
      upd.ringing = 1'b1;
    end
  end

  assign nxt      = upd;
  assign nxt_year = upd_year;

endmodule

FILE: rtl/rtc_calendar_with_alarm.sv
// ----------------------------------------------------------------------------
// rtc_calendar_with_alarm: time-of-day clock and calendar with daily alarm
//
// Usage: each input transfer carries a command in s_tuser (half-second tick,
// set time, set date, set alarm, acknowledge alarm) and its arguments in
// s_tdata. Every input transfer yields exactly one output transfer on m_*
// holding the full time, date and alarm status after that command.
// Two ticks make one second; seconds carry through minutes, hours, day,
// weekday, month and year, which wraps to 0 after YEAR_MAX.
// The command is captured in an input register when it is accepted; its
// result is registered in the output register, which drives m_tvalid, once
// that register is empty or being taken. Throughput is one command per cycle
// while m_tready is high, bounded by the single update pass between the two.
// Stall: while m_tready is low the result holds, one more command waits in
// the input register, and then s_tready drops until the result is taken.
// Reset: rst (synchronous) empties both registers and loads 00:00:00,
// day 1, month 1, year 16, weekday 1, alarm 00:00 armed, not ringing.
// ----------------------------------------------------------------------------
module rtc_calendar_with_alarm #(
  parameter int YEAR_MAX = rtc_pkg::YEAR_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // hour_in[4:0], minute_in[10:5], day_in[15:11], month_in[19:16],
  // year_in[25:20], weekday_in[28:26], alarm_enable_in[29], zero[31:30]
  input  logic [rtc_pkg::IN_DATA_W-1:0]     s_tdata,
  // command[2:0]
  input  logic [rtc_pkg::CMD_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // second_out[5:0], minute_out[11:6], hour_out[16:12], day_out[21:17],
  // month_out[25:22], year_out[31:26], weekday_out[34:32],
  // alarm_ringing[35], alarm_armed_out[36], zero[39:37]
  output logic [rtc_pkg::OUT_DATA_W-1:0]    m_tdata
);
  import rtc_pkg::*;

  localparam int YTOP = (YEAR_MAX > YEAR_RST) ? YEAR_MAX : YEAR_RST;
  localparam int YW   = $clog2(YTOP + 1);

  logic          in_valid;
  item_t         in_item;
  logic          out_valid;
  logic          adv;
  clock_state_t  st, st_next;
  logic [YW-1:0] year, year_next;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;
  assign m_tvalid = out_valid;

  rtc_step #(
    .YEAR_MAX (YEAR_MAX),
    .YW       (YW)
  ) u_step (
    .cur      (st),
    .cur_year (year),
    .item     (in_item),
    .nxt      (st_next),
    .nxt_year (year_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= CLOCK_RST;
      year      <= YW'(YEAR_RST);
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (adv) begin
        in_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
        st        <= st_next;
        year      <= year_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command         <= s_tuser;
      in_item.hour_in         <= s_tdata[4:0];
      in_item.minute_in       <= s_tdata[10:5];
      in_item.day_in          <= s_tdata[15:11];
      in_item.month_in        <= s_tdata[19:16];
      in_item.year_in         <= s_tdata[25:20];
      in_item.weekday_in      <= s_tdata[28:26];
      in_item.alarm_enable_in <= s_tdata[29];
    end
    if (adv) begin
      m_tdata <= {3'b000, st_next.armed, st_next.ringing, st_next.weekday_now,
                  YEAR_W'(year_next), st_next.month_now, st_next.day_of_month,
                  st_next.hours, st_next.minutes, st_next.seconds};
    end
  end

`ifndef SYNTHESIS
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    st.seconds <= SEC_LAST && st.minutes <= MIN_LAST && st.hours <= HOUR_LAST)
    else $error("time of day out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    st.day_of_month >= 5'd1 &&
    st.day_of_month <= month_len(st.month_now, year[1:0] == 2'b00))
    else $error("day of month beyond month length");

  a_ring_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(st.ringing) |-> st.armed && st.hours == st.alarm_hour &&
                          st.minutes == st.alarm_minute)
    else $error("alarm started without a matching armed alarm time");

  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("processed command left no result");

  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !adv |=> in_valid && $stable(in_item))
    else $error("waiting command lost or changed");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: calendar clock with daily alarm
// Drives commands over the input stream and checks every output transfer
// against a cycle-free model of the clock, date and alarm held in a
// scoreboard. Directed corner cases come first, then randomized episodes that
// set a date and time, often near a rollover, and run ticks through it, mixed with
// random noise commands. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
import rtc_pkg::*;

// arguments of one command, highest field first
typedef struct packed {
  logic       alarm_enable_in;
  logic [2:0] weekday_in;
  logic [5:0] year_in;
  logic [3:0] month_in;
  logic [4:0] day_in;
  logic [5:0] minute_in;
  logic [4:0] hour_in;
} clock_args_t;

// clock status as it leaves the block, highest field first
typedef struct packed {
  logic       armed;
  logic       ringing;
  logic [2:0] weekday;
  logic [5:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
} clock_view_t;

class clock_scoreboard;
  bit         half_phase;
  bit   [5:0] seconds;
  bit   [5:0] minutes;
  bit   [4:0] hours;
  bit   [4:0] day;
  bit   [3:0] month;
  bit   [5:0] year;
  bit   [2:0] weekday;
  bit   [4:0] alarm_hour;
  bit   [5:0] alarm_minute;
  bit         armed;
  bit         ringing;

  clock_view_t status_q[$];
  int errors;
  int checked;
  int rings;
  int days_rolled;
  int years_wrapped;

  function new();
    half_phase   = 1'b0;
    seconds      = '0;
    minutes      = '0;
    hours        = '0;
    day          = 5'd1;
    month        = 4'd1;
    year         = 6'(YEAR_RST);
    weekday      = 3'd1;
    alarm_hour   = '0;
    alarm_minute = '0;
    armed        = 1'b1;
    ringing      = 1'b0;
  endfunction

  function int month_length(int m, int y);
    if (m == 2) return (y % 4 == 0) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function int clip(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  function void roll_day();
    days_rolled++;
    weekday = (weekday >= WDAY_LAST) ? 3'd1 : weekday + 3'd1;
    if (day >= month_length(month, year)) begin
      day = 5'd1;
      if (month >= MONTH_LAST) begin
        month = 4'd1;
        if (year >= YEAR_MAX_DEF) begin
          year = '0;
          years_wrapped++;
        end else begin
          year = year + 6'd1;
        end
      end else begin
        month = month + 4'd1;
      end
    end else begin
      day = day + 5'd1;
    end
  endfunction

  // second ticks only on every other half-second tick
  function void half_tick();
    if (half_phase) begin
      if (seconds >= SEC_LAST) begin
        seconds = '0;
        if (minutes >= MIN_LAST) begin
          minutes = '0;
          if (hours >= HOUR_LAST) begin
            hours = '0;
            roll_day();
          end else begin
            hours = hours + 5'd1;
          end
        end else begin
          minutes = minutes + 6'd1;
        end
      end else begin
        seconds = seconds + 6'd1;
      end
    end
    half_phase = ~half_phase;
  endfunction

  function void note_input(logic [2:0] cmd, clock_args_t a);
    clock_view_t v;
    bit was_ringing;
    was_ringing = ringing;
    case (cmd)
      CMD_TICK: half_tick();
      CMD_SET_TIME: begin
        hours   = 5'(clip(a.hour_in, HOUR_LAST));
        minutes = 6'(clip(a.minute_in, MIN_LAST));
        seconds = '0;
      end
      CMD_SET_DATE: begin
        month   = (a.month_in == 0) ? 4'd1 : 4'(clip(a.month_in, MONTH_LAST));
        year    = 6'(clip(a.year_in, YEAR_MAX_DEF));
        day     = 5'(clip(a.day_in, month_length(month, year)));
        if (day == 0) day = 5'd1;
        weekday = (a.weekday_in == 0) ? 3'd1 : a.weekday_in;
      end
      CMD_SET_ALARM: begin
        alarm_hour   = 5'(clip(a.hour_in, HOUR_LAST));
        alarm_minute = 6'(clip(a.minute_in, MIN_LAST));
        armed        = a.alarm_enable_in;
      end
      CMD_ACK: begin
        if (ringing) begin
          ringing = 1'b0;
          armed   = 1'b0;
        end
      end
      default: ;
    endcase
    // alarm compare runs after every command
    if (armed && hours == alarm_hour && minutes == alarm_minute) ringing = 1'b1;
    if (ringing && !was_ringing) rings++;
    v.second  = seconds;
    v.minute  = minutes;
    v.hour    = hours;
    v.day     = day;
    v.month   = month;
    v.year    = year;
    v.weekday = weekday;
    v.ringing = ringing;
    v.armed   = armed;
    status_q.push_back(v);
  endfunction

  function void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(logic [OUT_DATA_W-1:0] raw);
    clock_view_t exp_v;
    clock_view_t act_v;
    act_v = raw[$bits(clock_view_t)-1:0];
    if (status_q.size() == 0) begin
      $error("output transfer with no pending command: 0x%0h", raw);
      errors++;
      return;
    end
    exp_v = status_q.pop_front();
    checked++;
    check_field("second_out", exp_v.second, act_v.second);
    check_field("minute_out", exp_v.minute, act_v.minute);
    check_field("hour_out", exp_v.hour, act_v.hour);
    check_field("day_out", exp_v.day, act_v.day);
    check_field("month_out", exp_v.month, act_v.month);
    check_field("year_out", exp_v.year, act_v.year);
    check_field("weekday_out", exp_v.weekday, act_v.weekday);
    check_field("alarm_ringing", exp_v.ringing, act_v.ringing);
    check_field("alarm_armed_out", exp_v.armed, act_v.armed);
  endfunction

  function int pending();
    return status_q.size();
  endfunction
endclass

module testbench;
  localparam int RUN_ITEMS  = 1300;
  localparam int CYCLE_CAP  = 1000000;
  localparam int DRAIN_WAIT = 8;
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // hour_in, minute_in, day_in, month_in, year_in, weekday_in, alarm_enable_in
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // command
  logic [CMD_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // second_out, minute_out, hour_out, day_out, month_out, year_out,
  // weekday_out, alarm_ringing, alarm_armed_out
  logic [OUT_DATA_W-1:0] m_tdata;

  clock_scoreboard sb;
  int sent;
  int cycle;
  bit quiet;

  rtc_calendar_with_alarm dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, none during quiet stretches
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic clock_args_t make_args(int hour, int minute, int day, int month,
                                            int year, int weekday, int enable);
    clock_args_t a;
    a.hour_in         = 5'(hour);
    a.minute_in       = 6'(minute);
    a.day_in          = 5'(day);
    a.month_in        = 4'(month);
    a.year_in         = 6'(year);
    a.weekday_in      = 3'(weekday);
    a.alarm_enable_in = 1'(enable);
    return a;
  endfunction

  function automatic clock_args_t random_args();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(clock_args_t)-1:0];
  endfunction

  task automatic send_item(input logic [2:0] cmd, input clock_args_t a);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(IN_DATA_W - $bits(clock_args_t)){1'b0}}, a};
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, a);
    sent++;
  endtask

  // noise, or set a date and time, maybe an alarm on the next minute, then tick
  task automatic run_episode();
    int kind;
    int n;
    int hr;
    int mn;
    clock_args_t a;
    kind = $urandom_range(0, 4);
    if (kind == 4) begin
      n = $urandom_range(1, 8);
      repeat (n) send_item(3'($urandom_range(0, 7)), random_args());
      return;
    end
    a = random_args();
    a.month_in   = (kind == 0) ? MONTH_LAST : 4'($urandom_range(1, 12));
    a.day_in     = (kind <= 1) ? 5'd31 : 5'($urandom_range(1, 31));
    a.year_in    = (kind == 0 && $urandom_range(0, 1) == 1) ? 6'(YEAR_MAX_DEF)
                                                             : 6'($urandom_range(0, 50));
    a.weekday_in = 3'($urandom_range(1, 7));
    send_item(CMD_SET_DATE, a);
    hr = (kind <= 1) ? HOUR_LAST : $urandom_range(0, 23);
    mn = (kind <= 1 || $urandom_range(0, 1) == 1) ? MIN_LAST : $urandom_range(0, 59);
    a = random_args();
    a.hour_in   = 5'(hr);
    a.minute_in = 6'(mn);
    send_item(CMD_SET_TIME, a);
    if ($urandom_range(0, 1) == 1) begin
      if (mn == MIN_LAST) begin
        mn = 0;
        hr = (hr == HOUR_LAST) ? 0 : hr + 1;
      end else begin
        mn = mn + 1;
      end
      a = random_args();
      a.hour_in         = 5'(hr);
      a.minute_in       = 6'(mn);
      a.alarm_enable_in = ($urandom_range(0, 3) != 0);
      send_item(CMD_SET_ALARM, a);
    end
    // 120 ticks after a time set carry exactly one minute
    n = (kind <= 1) ? $urandom_range(118, 128) : $urandom_range(2, 60);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        send_item(CMD_ACK, random_args());
      else if ($urandom_range(0, 49) == 0)
        send_item(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)), random_args());
      else
        send_item(CMD_TICK, random_args());
    end
  endtask

  // output side: check transfers and drive random backpressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      cycle++;
      quiet = ((cycle / 256) % 4) == 3;
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset state matches the alarm at once, so the first command rings
    send_item(CMD_TICK, make_args(0, 0, 1, 1, 0, 1, 0));
    send_item(CMD_ACK, random_args());
    send_item(CMD_ACK, random_args());
    send_item(CMD_SET_TIME, make_args(31, 63, 0, 0, 0, 0, 1));
    send_item(CMD_SET_TIME, make_args(23, 59, 31, 15, 63, 7, 0));
    send_item(CMD_SET_DATE, make_args(0, 0, 31, 12, 50, 7, 0));
    send_item(CMD_SET_DATE, make_args(31, 63, 0, 0, 0, 0, 1));
    send_item(CMD_SET_DATE, make_args(0, 0, 31, 15, 63, 7, 0));
    send_item(CMD_SET_DATE, make_args(0, 0, 31, 2, 48, 3, 0));
    send_item(CMD_SET_DATE, make_args(0, 0, 30, 2, 49, 4, 0));
    send_item(CMD_SET_DATE, make_args(0, 0, 31, 4, 1, 5, 0));
    // alarm equal to the current time but disarmed must stay quiet
    send_item(CMD_SET_ALARM, make_args(23, 59, 0, 0, 0, 0, 0));
    send_item(CMD_SET_ALARM, make_args(31, 63, 0, 0, 0, 0, 1));
    // changing the alarm leaves it ringing
    send_item(CMD_SET_ALARM, make_args(5, 30, 0, 0, 0, 0, 1));
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_item(3'(c), random_args());
    send_item(CMD_ACK, random_args());
    send_item(CMD_SET_TIME, make_args(0, 0, 0, 0, 0, 0, 0));
    send_item(CMD_TICK, random_args());
    send_item(CMD_TICK, random_args());
    send_item(CMD_SET_ALARM, make_args(0, 0, 0, 0, 0, 0, 1));

    while (sent < RUN_ITEMS) run_episode();
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d commands, checked %0d status transfers", sent, sb.checked);
    $display("alarm rang %0d times, %0d day rollovers, %0d year wraps",
             sb.rings, sb.days_rolled, sb.years_wrapped);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

FILE: rtc_calendar_with_alarm.f
rtl/rtc_pkg.sv
rtl/rtc_step.sv
rtl/rtc_calendar_with_alarm.sv
tb/testbench.sv
